@@ rtl/mrsd_pkg.sv @@
// ----------------------------------------------------------------------------
// mrsd_pkg
// Shared types and constants of the motion record stream decoder.
// ----------------------------------------------------------------------------
package mrsd_pkg;

  localparam int unsigned IDX_W       = 6;
  localparam int unsigned LEN_FULL    = 37;
  localparam int unsigned LEN_COMPACT = 8;
  localparam int unsigned LEN_W       = 6;

  localparam logic [7:0] FLAG_END = 8'hFF;
  localparam int unsigned BIT_RECORD  = 3;
  localparam int unsigned BIT_FLAGONLY = 5;
  localparam int unsigned BIT_COMPACT = 7;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_COMPACT  = 2'd1;
  localparam logic [1:0] ST_SKIPPED  = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_END,
    EV_SKIP,
    EV_TRUNC,
    EV_FULL,
    EV_FULL_FLAG,
    EV_CMP,
    EV_CMP_FLAG
  } ev_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
    logic       ejected;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LEN_W-1:0]  record_length;
    logic [7:0]        flag_out;
    logic [31:0]       pos_x;
    logic [31:0]       pos_y;
    logic [31:0]       pos_z;
    logic [15:0]       orient_x;
    logic [15:0]       orient_y;
    logic [15:0]       orient_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
  } out_t;

  // Decoded record handed from the assembler to the motion state.
  typedef struct packed {
    ev_kind_e          kind;
    logic [7:0]        flag;
    logic [2:0][31:0]  full_pos;
    logic [2:0][15:0]  full_ori;
    logic [2:0][15:0]  full_vel;
    logic [2:0][7:0]   cmp_acc;
    logic [2:0][15:0]  cmp_ori;
  } ev_t;

  // Stored motion state: flag, position, orientation and velocity.
  typedef struct packed {
    logic [7:0]        flag;
    logic [2:0][31:0]  pos;
    logic [2:0][15:0]  ori;
    logic [2:0][15:0]  vel;
  } motion_t;

endpackage

@@ rtl/mrsd_assembler.sv @@
// ----------------------------------------------------------------------------
// mrsd_assembler
// Collects record bytes in a shift line and classifies each byte's outcome.
// ----------------------------------------------------------------------------
module mrsd_assembler (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  mrsd_pkg::in_t item_i,
  output mrsd_pkg::ev_t ev_o
);
  import mrsd_pkg::*;

  logic [IDX_W-1:0]            idx_q, idx_d, idx_inc, need;
  logic [7:0]                  flag_buf_q, flag_buf_d;
  logic                        held_ej_q, held_ej_d;
  logic [LEN_FULL-2:0][7:0]    sh_q;
  logic                        first, compact, done;
  logic [7:0]                  full_b [1:LEN_FULL-1];
  logic [7:0]                  cmp_b  [1:LEN_COMPACT-1];
  ev_t                         ev_d;

  // Byte k of a finishing record sits need-2-k places down the shift line.
  always_comb begin
    for (int k = 1; k < LEN_FULL - 1; k++) begin
      full_b[k] = sh_q[LEN_FULL-2-k];
    end
    full_b[LEN_FULL-1] = item_i.data_byte;
    for (int k = 1; k < LEN_COMPACT - 1; k++) begin
      cmp_b[k] = sh_q[LEN_COMPACT-2-k];
    end
    cmp_b[LEN_COMPACT-1] = item_i.data_byte;
  end

  always_comb begin
    idx_inc    = idx_q + IDX_W'(1);
    first      = (idx_q == '0);
    compact    = flag_buf_q[BIT_COMPACT];
    need       = compact ? IDX_W'(LEN_COMPACT) : IDX_W'(LEN_FULL);
    done       = !first && (idx_inc == need);
    idx_d      = idx_q;
    flag_buf_d = flag_buf_q;
    held_ej_d  = held_ej_q;
    ev_d.kind  = EV_NONE;
    ev_d.flag  = flag_buf_q;

    priority if (first) begin
      held_ej_d = item_i.ejected;
      priority if (item_i.data_byte == FLAG_END) begin
        ev_d.kind = EV_END;
        ev_d.flag = FLAG_END;
      end else if (!item_i.data_byte[BIT_RECORD]) begin
        ev_d.kind = EV_SKIP;
      end else begin
        flag_buf_d = item_i.data_byte;
        if (item_i.end_of_buffer) begin
          ev_d.kind = EV_TRUNC;
        end else begin
          idx_d = IDX_W'(1);
        end
      end
    end else if (done) begin
      idx_d = '0;
      if (compact) begin
        ev_d.kind = held_ej_q ? EV_CMP_FLAG : EV_CMP;
      end else begin
        ev_d.kind = (held_ej_q || flag_buf_q[BIT_FLAGONLY]) ? EV_FULL_FLAG : EV_FULL;
      end
    end else if (item_i.end_of_buffer) begin
      idx_d     = '0;
      ev_d.kind = EV_TRUNC;
    end else begin
      idx_d = idx_inc;
    end

    // Little-endian field image of a full record, and the compact unpacking.
    for (int i = 0; i < 3; i++) begin
      ev_d.full_pos[i] = {full_b[4+4*i], full_b[3+4*i], full_b[2+4*i], full_b[1+4*i]};
      ev_d.full_ori[i] = {full_b[14+2*i], full_b[13+2*i]};
      ev_d.full_vel[i] = {full_b[20+4*i], full_b[19+4*i]};
      ev_d.cmp_acc[i]  = cmp_b[1+i];
      ev_d.cmp_ori[i]  = {cmp_b[4+i], cmp_b[LEN_COMPACT-1][(4-2*i)+:2], 6'b0};
    end
  end

  assign ev_o = ev_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      flag_buf_q <= '0;
      held_ej_q  <= 1'b0;
    end else if (fire_i) begin
      idx_q      <= idx_d;
      flag_buf_q <= flag_buf_d;
      held_ej_q  <= held_ej_d;
    end
  end

  // Shift in every byte after the flag.
  always_ff @(posedge clk_i) begin
    if (fire_i && !first) begin
      sh_q <= {sh_q[LEN_FULL-3:0], item_i.data_byte};
    end
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(LEN_FULL - 1))
    else $error("byte index beyond full record length");

  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!first && compact) |-> (idx_q < IDX_W'(LEN_COMPACT)))
    else $error("compact record ran past its length");

  a_idx_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && ev_d.kind != EV_NONE) |=> (idx_q == '0))
    else $error("byte index not cleared after a result");
`endif

endmodule

@@ rtl/mrsd_motion.sv @@
// ----------------------------------------------------------------------------
// mrsd_motion
// Stored flag and motion state, updated from each decoded record.
// ----------------------------------------------------------------------------
module mrsd_motion (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  mrsd_pkg::ev_t     ev_i,
  output mrsd_pkg::motion_t state_d_o
);
  import mrsd_pkg::*;

  motion_t    st_q, st_d;
  logic [15:0] low;

  always_comb begin
    st_d = st_q;
    low  = '0;
    unique case (ev_i.kind)
      EV_END, EV_FULL_FLAG, EV_CMP_FLAG: begin
        st_d.flag = ev_i.flag;
      end
      EV_FULL: begin
        st_d.flag = ev_i.flag;
        st_d.pos  = ev_i.full_pos;
        st_d.ori  = ev_i.full_ori;
        st_d.vel  = ev_i.full_vel;
      end
      EV_CMP: begin
        st_d.flag = ev_i.flag;
        st_d.ori  = ev_i.cmp_ori;
        for (int i = 0; i < 3; i++) begin
          low         = st_q.vel[i] + {{8{ev_i.cmp_acc[i][7]}}, ev_i.cmp_acc[i]};
          st_d.vel[i] = low;
          st_d.pos[i] = st_q.pos[i] + {{16{low[15]}}, low};
        end
      end
      EV_NONE, EV_SKIP, EV_TRUNC: begin
        st_d = st_q;
      end
    endcase
  end

  assign state_d_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule

@@ rtl/motion_record_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// motion_record_stream_decoder
// Byte-stream decoder of motion records with stored flag and motion state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one stream byte
//   per item, with its end-of-buffer mark and the ejected flag. Output
//   channel (out_valid_o / out_stall_i / out_item_o) gives one item for each
//   finished record, end marker, skipped byte or truncation; bytes in the
//   middle of a record give none.
//   An item taken lands in the input register, is decoded into the result
//   register once that is free or draining, and is shown from then on.
//   Throughput: one byte per cycle unless the receiver stalls a waiting
//   result, set by the single decode step between the input register and
//   the result register (a velocity and a position add per axis at most).
//   Reset clears the byte count, the held ejected flag and all motion state;
//   the record shift line is not cleared and is only read once written.
//   While the receiver stalls with a result waiting, the pending byte holds
//   in the input register and in_stall_o rises once that register is full.
// ----------------------------------------------------------------------------
module motion_record_stream_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mrsd_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mrsd_pkg::out_t out_item_o
);
  import mrsd_pkg::*;

  logic    s1_valid_q;
  in_t     s1_item_q;
  logic    s1_adv, in_fire, has_res;
  logic    res_valid_q;
  out_t    res_item_q, res_item_d;
  ev_t     ev;
  motion_t st_d;

  // Advance the held byte whenever the result register is free or draining.
  assign s1_adv     = s1_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign has_res    = (ev.kind != EV_NONE);

  mrsd_assembler u_asm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_adv),
    .item_i (s1_item_q),
    .ev_o   (ev)
  );

  mrsd_motion u_motion (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_adv),
    .ev_i      (ev),
    .state_d_o (st_d)
  );

  // Result item: status and length by outcome, state after the record.
  always_comb begin
    res_item_d.flag_out = st_d.flag;
    res_item_d.pos_x    = st_d.pos[0];
    res_item_d.pos_y    = st_d.pos[1];
    res_item_d.pos_z    = st_d.pos[2];
    res_item_d.orient_x = st_d.ori[0];
    res_item_d.orient_y = st_d.ori[1];
    res_item_d.orient_z = st_d.ori[2];
    res_item_d.vel_x    = st_d.vel[0];
    res_item_d.vel_y    = st_d.vel[1];
    res_item_d.vel_z    = st_d.vel[2];
    unique case (ev.kind)
      EV_END: begin
        res_item_d.status        = ST_ACCEPTED;
        res_item_d.record_length = LEN_W'(1);
      end
      EV_SKIP: begin
        res_item_d.status        = ST_SKIPPED;
        res_item_d.record_length = LEN_W'(1);
      end
      EV_FULL, EV_FULL_FLAG: begin
        res_item_d.status        = ST_ACCEPTED;
        res_item_d.record_length = LEN_W'(LEN_FULL);
      end
      EV_CMP: begin
        res_item_d.status        = ST_COMPACT;
        res_item_d.record_length = LEN_W'(LEN_COMPACT);
      end
      EV_CMP_FLAG: begin
        res_item_d.status        = ST_ACCEPTED;
        res_item_d.record_length = LEN_W'(LEN_COMPACT);
      end
      EV_TRUNC, EV_NONE: begin
        res_item_d.status        = ST_TRUNC;
        res_item_d.record_length = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && has_res) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on handshake, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
    if (s1_adv && has_res) begin
      res_item_q <= res_item_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_item_q;

`ifndef ASSERT_OFF
  a_trunc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_TRUNC) |-> (out_item_o.record_length == '0))
    else $error("truncation item with non-zero length");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && out_stall_i) |-> !s1_adv)
    else $error("decode advanced over a stalled result");

  a_cmp_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && ev.kind == EV_CMP) |=> (out_valid_o && out_item_o.status == ST_COMPACT))
    else $error("compact integration did not produce its result");
`endif

endmodule
